// ===== rtl/lfp_pkg.sv =====
// lfp_pkg: shared types, character codes, result codes and the code decoder
// for the length-prefixed frame parser. No dependencies.

package lfp_pkg;

   localparam int LEN_W             = 17;
   localparam int CNT_W             = 4;
   localparam int LENGTH_DIGITS_MAX = 15;
   localparam int PROD_W            = LEN_W + 4;

   localparam logic [LEN_W-1:0] MAX_BODY_RESET = LEN_W'(99999);

   localparam logic [7:0] CHAR_PIPE = 8'h7C;
   localparam logic [7:0] CHAR_ONE  = 8'h31;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [23:0] CODE_NAM = 24'h4E414D;
   localparam logic [23:0] CODE_SET = 24'h534554;
   localparam logic [23:0] CODE_WHO = 24'h57484F;
   localparam logic [23:0] CODE_MSG = 24'h4D5347;

   // message codes as reported on the result channel
   localparam logic [1:0] MSG_NAM = 2'd0;
   localparam logic [1:0] MSG_SET = 2'd1;
   localparam logic [1:0] MSG_WHO = 2'd2;
   localparam logic [1:0] MSG_MSG = 2'd3;

   localparam logic [1:0] KIND_CONTENT = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   localparam logic [2:0] CAUSE_NONE      = 3'd0;
   localparam logic [2:0] CAUSE_VER_POS   = 3'd1;
   localparam logic [2:0] CAUSE_VER_CHAR  = 3'd2;
   localparam logic [2:0] CAUSE_CODE_LEN  = 3'd3;
   localparam logic [2:0] CAUSE_CODE_UNK  = 3'd4;
   localparam logic [2:0] CAUSE_LEN_DIGIT = 3'd5;
   localparam logic [2:0] CAUSE_LEN_LARGE = 3'd6;
   localparam logic [2:0] CAUSE_BAD_BODY  = 3'd7;

   typedef enum logic [3:0] {
      PH_VERSION = 4'b0001,
      PH_CODE    = 4'b0010,
      PH_LENGTH  = 4'b0100,
      PH_BODY    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic             digit_bad;
      logic             overflow;
      logic [LEN_W-1:0] acc;
   } len_next_type;

   typedef struct packed {
      logic       known;
      logic [1:0] code;
   } msg_code_type;

   function automatic msg_code_type decode_code(input logic [23:0] bytes,
                                                input logic len_bad);
      msg_code_type r;
      r.known = 1'b1;
      r.code  = MSG_NAM;
      if (len_bad) begin
         r.known = 1'b0;
      end else if (bytes == CODE_NAM) begin
         r.code = MSG_NAM;
      end else if (bytes == CODE_SET) begin
         r.code = MSG_SET;
      end else if (bytes == CODE_WHO) begin
         r.code = MSG_WHO;
      end else if (bytes == CODE_MSG) begin
         r.code = MSG_MSG;
      end else begin
         r.known = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== rtl/length_prefixed_frame_parser_core.sv =====
// length_prefixed_frame_parser_core: top level of the frame parser.
// Depends on lfp_pkg and lfp_length_digit.
//
// Usage:
//   req_ channel carries one stream byte per transfer (req_rx_byte) and a
//   restart flag (req_restart) that returns the parser to frame start and
//   drops the byte. rsp_ channel gives at most one result per byte: a body
//   content byte with its field index, a frame accept, or a frame reject with
//   its cause. csr_ channel writes the largest accepted body length; it is
//   always ready and should only be written while no result is pending.
//   Throughput: one byte per cycle while req_ready is high. A byte is parsed in
//   the cycle it is taken and its result sits in the output register from the
//   next cycle. The single output register sets the rate: req_ready is high
//   while that register is empty or being drained, so a stalled receiver holds
//   off the sender only while a result is waiting.
//   Bytes that give no result pass straight through with no rsp_ transfer.
//   After a reject the parser stays silent until a restart transfer.
//   Reset (synchronous) empties the output register, returns to frame start
//   and restores the maximum body length to 99999.

module length_prefixed_frame_parser_core
   import lfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   input  logic             req_restart,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_field_index,
   output logic [1:0]       rsp_message_code,
   output logic [2:0]       rsp_reject_cause,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_max_body_length
);

   logic [LEN_W-1:0] max_len_ff;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [23:0]      code_ff, code_in;
   logic [LEN_W-1:0] acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [1:0]       sep_ff, sep_in;
   logic             halted_ff, halted_in;
   logic             ver_pos_bad_ff, ver_pos_bad_in;
   logic             ver_char_bad_ff, ver_char_bad_in;
   logic             first_one_ff, first_one_in;
   logic             code_len_bad_ff, code_len_bad_in;
   logic             len_bad_ff, len_bad_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [1:0]       out_field_ff, out_field_in;
   logic [1:0]       out_code_ff, out_code_in;
   logic [2:0]       out_cause_ff, out_cause_in;

   logic             req_xfer;
   logic             is_pipe;
   logic             len_bad_eff;
   logic             is_msg;
   msg_code_type     dec;
   len_next_type     len_next;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_field_index  = out_field_ff;
   assign rsp_message_code = out_code_ff;
   assign rsp_reject_cause = out_cause_ff;

   lfp_length_digit u_digit (
      .acc      (acc_ff),
      .overflow (ovf_ff),
      .rx_byte  (req_rx_byte),
      .max_len  (max_len_ff),
      .next     (len_next)
   );

   assign is_pipe     = (req_rx_byte == CHAR_PIPE);
   assign dec         = decode_code(code_ff, code_len_bad_ff);
   assign is_msg      = dec.known && (dec.code == MSG_MSG);
   assign len_bad_eff = len_bad_ff || (cnt_ff == '0);

   always_comb begin
      phase_in        = phase_ff;
      cnt_in          = cnt_ff;
      code_in         = code_ff;
      acc_in          = acc_ff;
      ovf_in          = ovf_ff;
      remain_in       = remain_ff;
      sep_in          = sep_ff;
      halted_in       = halted_ff;
      ver_pos_bad_in  = ver_pos_bad_ff;
      ver_char_bad_in = ver_char_bad_ff;
      first_one_in    = first_one_ff;
      code_len_bad_in = code_len_bad_ff;
      len_bad_in      = len_bad_ff;

      // output register drains on a transfer, reloads below
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_field_in = out_field_ff;
      out_code_in  = out_code_ff;
      out_cause_in = out_cause_ff;

      if (req_xfer) begin
         // prepare a result template; loaded only where out_valid_in is set
         out_kind_in  = KIND_REJECT;
         out_byte_in  = 8'h00;
         out_field_in = 2'd0;
         out_code_in  = dec.known ? dec.code : MSG_NAM;
         out_cause_in = CAUSE_NONE;

         if (req_restart) begin
            halted_in = 1'b0;
         end
         if (req_restart || (phase_ff == PH_BODY && !halted_ff && remain_ff <= LEN_W'(1)
                             && is_pipe && !(is_msg && sep_ff < 2'd2))) begin
            // frame start
            phase_in        = PH_VERSION;
            cnt_in          = '0;
            code_in         = '0;
            acc_in          = '0;
            ovf_in          = 1'b0;
            remain_in       = '0;
            sep_in          = 2'd0;
            ver_pos_bad_in  = 1'b0;
            ver_char_bad_in = 1'b0;
            first_one_in    = 1'b0;
            code_len_bad_in = 1'b0;
            len_bad_in      = 1'b0;
         end

         if (!req_restart && !halted_ff) begin
            case (phase_ff)
               PH_VERSION: begin
                  if (is_pipe) begin
                     ver_pos_bad_in  = (cnt_ff != CNT_W'(1));
                     ver_char_bad_in = !first_one_ff;
                     cnt_in          = '0;
                     phase_in        = PH_CODE;
                  end else begin
                     if (cnt_ff == '0) begin
                        first_one_in = (req_rx_byte == CHAR_ONE);
                     end
                     if (cnt_ff < CNT_W'(2)) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
               end
               PH_CODE: begin
                  if (is_pipe) begin
                     code_len_bad_in = (cnt_ff != CNT_W'(3));
                     cnt_in          = '0;
                     phase_in        = PH_LENGTH;
                  end else begin
                     code_in = {code_ff[15:0], req_rx_byte};
                     if (cnt_ff < CNT_W'(4)) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
               end
               PH_LENGTH: begin
                  if (!is_pipe) begin
                     acc_in = len_next.acc;
                     ovf_in = len_next.overflow;
                     if (len_next.digit_bad) begin
                        len_bad_in = 1'b1;
                     end
                     if (cnt_ff >= CNT_W'(LENGTH_DIGITS_MAX)) begin
                        len_bad_in = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end else begin
                     len_bad_in   = len_bad_eff;
                     out_valid_in = 1'b1;
                     halted_in    = 1'b1;
                     // header checks in priority order
                     if (ver_pos_bad_ff) begin
                        out_cause_in = CAUSE_VER_POS;
                     end else if (len_bad_eff) begin
                        out_cause_in = CAUSE_LEN_DIGIT;
                     end else if (ovf_ff) begin
                        out_cause_in = CAUSE_LEN_LARGE;
                     end else if (ver_char_bad_ff) begin
                        out_cause_in = CAUSE_VER_CHAR;
                     end else if (code_len_bad_ff) begin
                        out_cause_in = CAUSE_CODE_LEN;
                     end else if (!dec.known) begin
                        out_cause_in = CAUSE_CODE_UNK;
                     end else if (acc_ff == '0) begin
                        out_cause_in = CAUSE_BAD_BODY;
                     end else begin
                        out_valid_in = out_valid_ff && !rsp_ready;
                        halted_in    = 1'b0;
                        remain_in    = acc_ff;
                        sep_in       = 2'd0;
                        phase_in     = PH_BODY;
                     end
                  end
               end
               PH_BODY: begin
                  if (remain_ff <= LEN_W'(1)) begin
                     out_valid_in = 1'b1;
                     if (!is_pipe || (is_msg && sep_ff < 2'd2)) begin
                        out_cause_in = CAUSE_BAD_BODY;
                        halted_in    = 1'b1;
                     end else begin
                        out_kind_in = KIND_ACCEPT;
                     end
                  end else begin
                     remain_in = remain_ff - LEN_W'(1);
                     if (is_msg && is_pipe && sep_ff < 2'd2) begin
                        // field separator, not content
                        sep_in = sep_ff + 2'd1;
                     end else begin
                        out_valid_in = 1'b1;
                        out_kind_in  = KIND_CONTENT;
                        out_byte_in  = req_rx_byte;
                        out_field_in = is_msg ? sep_ff : 2'd0;
                     end
                  end
               end
               default: begin
                  phase_in = PH_VERSION;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_BODY_RESET;
      end else if (csr_valid && csr_ready) begin
         max_len_ff <= csr_max_body_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_VERSION;
         cnt_ff          <= '0;
         code_ff         <= '0;
         acc_ff          <= '0;
         ovf_ff          <= 1'b0;
         remain_ff       <= '0;
         sep_ff          <= 2'd0;
         halted_ff       <= 1'b0;
         ver_pos_bad_ff  <= 1'b0;
         ver_char_bad_ff <= 1'b0;
         first_one_ff    <= 1'b0;
         code_len_bad_ff <= 1'b0;
         len_bad_ff      <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         cnt_ff          <= cnt_in;
         code_ff         <= code_in;
         acc_ff          <= acc_in;
         ovf_ff          <= ovf_in;
         remain_ff       <= remain_in;
         sep_ff          <= sep_in;
         halted_ff       <= halted_in;
         ver_pos_bad_ff  <= ver_pos_bad_in;
         ver_char_bad_ff <= ver_char_bad_in;
         first_one_ff    <= first_one_in;
         code_len_bad_ff <= code_len_bad_in;
         len_bad_ff      <= len_bad_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (out_valid_in && !(out_valid_ff && !rsp_ready)) begin
         out_kind_ff  <= out_kind_in;
         out_byte_ff  <= out_byte_in;
         out_field_ff <= out_field_in;
         out_code_ff  <= out_code_in;
         out_cause_ff <= out_cause_in;
      end
   end

endmodule

// ===== rtl/lfp_length_digit.sv =====
// lfp_length_digit: folds one length character into the decimal accumulator,
// with the sticky overflow against the configured maximum. Uses lfp_pkg.

module lfp_length_digit
   import lfp_pkg::*;
(
   input  logic [LEN_W-1:0] acc,
   input  logic             overflow,
   input  logic [7:0]       rx_byte,
   input  logic [LEN_W-1:0] max_len,
   output len_next_type     next
);

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] sum;
   logic [3:0]        digit;

   always_comb begin
      // low nibble of an ascii digit is its value
      digit = rx_byte[3:0];
      // times ten as two shifts and an add
      prod  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
      sum   = prod + PROD_W'(digit);

      next.digit_bad = 1'b0;
      next.overflow  = overflow;
      next.acc       = acc;
      if (rx_byte < CHAR_ZERO || rx_byte > CHAR_NINE) begin
         next.digit_bad = 1'b1;
      end else if (sum > PROD_W'(max_len)) begin
         next.overflow = 1'b1;
      end else if (!overflow) begin
         next.acc = sum[LEN_W-1:0];
      end
   end

endmodule
